### design/ttip_pkg.sv
// ----------------------------------------------------------------------------
// Text-to-integer parser package
// Character codes, bases, field widths and the classified character record
// that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package ttip_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned RADIX_W       = 5;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned CNT_W         = 8;
  localparam int unsigned CNT_FIELD_MAX = 255;

  localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;
  localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;

  localparam logic [RADIX_W-1:0] BASE_AUTO  = 5'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT   = 5'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC   = 5'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX   = 5'd16;
  localparam logic [RADIX_W-1:0] DIGIT_NONE = 5'd16;

  typedef struct packed {
    logic               term;
    logic               last;
    logic               ws;
    logic               minus;
    logic               plus;
    logic               zero;
    logic               hex_x;
    logic [RADIX_W-1:0] digit;
  } tok_t;

endpackage

### design/ttip_front.sv
// ----------------------------------------------------------------------------
// Text-to-integer parser front end
// Classifies one incoming character into the flags and digit value used by
// the back end.
// ----------------------------------------------------------------------------
module ttip_front (
  input  logic [ttip_pkg::CH_W-1:0] ch_i,
  input  logic                      last_i,
  output ttip_pkg::tok_t            tok_o
);
  import ttip_pkg::*;

  logic [CH_W-1:0] off_num;
  logic [CH_W-1:0] off_low;
  logic [CH_W-1:0] off_up;

  assign off_num = ch_i - CH_ZERO;
  assign off_low = ch_i - CH_LOWER_A + 8'd10;
  assign off_up  = ch_i - CH_UPPER_A + 8'd10;

  always_comb begin
    tok_o.term  = (ch_i == CH_NUL);
    tok_o.last  = last_i;
    tok_o.ws    = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
    tok_o.minus = (ch_i == CH_MINUS);
    tok_o.plus  = (ch_i == CH_PLUS);
    tok_o.zero  = (ch_i == CH_ZERO);
    tok_o.hex_x = (ch_i == CH_LOWER_X) || (ch_i == CH_UPPER_X);
    priority if (ch_i >= CH_ZERO && ch_i <= CH_NINE) begin
      tok_o.digit = off_num[RADIX_W-1:0];
    end else if (ch_i >= CH_LOWER_A && ch_i <= CH_LOWER_F) begin
      tok_o.digit = off_low[RADIX_W-1:0];
    end else if (ch_i >= CH_UPPER_A && ch_i <= CH_UPPER_F) begin
      tok_o.digit = off_up[RADIX_W-1:0];
    end else begin
      tok_o.digit = DIGIT_NONE;
    end
  end

endmodule

### design/ttip_queue.sv
// ----------------------------------------------------------------------------
// Text-to-integer parser queue
// Two-entry queue of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module ttip_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ttip_pkg::tok_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ttip_pkg::tok_t data_o
);
  import ttip_pkg::*;

  tok_t       slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

### design/ttip_back.sv
// ----------------------------------------------------------------------------
// Text-to-integer parser back end
// Runs the parsing phases on classified characters, accumulates the signed
// value with one multiply-add per digit and holds the result for delivery.
// ----------------------------------------------------------------------------
module ttip_back #(
  parameter logic [ttip_pkg::CNT_W-1:0] CntLimit = ttip_pkg::CNT_W'(ttip_pkg::CNT_FIELD_MAX)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ttip_pkg::RADIX_W-1:0]   radix_i,
  input  logic                           tok_valid_i,
  input  ttip_pkg::tok_t                 tok_i,
  output logic                           tok_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [ttip_pkg::VALUE_W-1:0] value_o,
  output logic [ttip_pkg::CNT_W-1:0]     end_offset_o
);
  import ttip_pkg::*;

  localparam logic [2:0] PhWs     = 3'd0;
  localparam logic [2:0] PhPrefix = 3'd1;
  localparam logic [2:0] PhZero   = 3'd2;
  localparam logic [2:0] PhDigits = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [RADIX_W-1:0] base_q, base_d;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]   offset_q;

  logic               prefix_step, digit_step, consume, emit;
  logic [RADIX_W-1:0] mul_base;
  logic [VALUE_W-1:0] product, delta;

  // The accumulator carries the sign, so a minus sign needs no final negation.
  assign product = acc_q * {{(VALUE_W-RADIX_W){1'b0}}, mul_base};
  assign delta   = neg_q ? ({VALUE_W{1'b0}} - VALUE_W'(tok_i.digit))
                         : VALUE_W'(tok_i.digit);

  assign emit      = tok_i.term || tok_i.last;
  assign tok_pop_o = tok_valid_i && !(emit && out_valid_q && !out_ready_i);

  always_comb begin
    phase_d     = phase_q;
    base_d      = base_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    prefix_step = 1'b0;
    digit_step  = 1'b0;
    consume     = 1'b0;
    mul_base    = base_q;
    if (!tok_i.term) begin
      unique case (phase_q)
        PhWs: begin
          if (tok_i.ws) begin
            consume = 1'b1;
          end else begin
            phase_d = PhPrefix;
            if (tok_i.minus) begin
              neg_d   = 1'b1;
              consume = 1'b1;
            end else if (tok_i.plus) begin
              consume = 1'b1;
            end else begin
              prefix_step = 1'b1;
            end
          end
        end
        PhPrefix: begin
          prefix_step = 1'b1;
        end
        PhZero: begin
          if (tok_i.hex_x) begin
            base_d  = BASE_HEX;
            consume = 1'b1;
            phase_d = PhDigits;
          end else begin
            base_d     = BASE_OCT;
            mul_base   = BASE_OCT;
            digit_step = 1'b1;
          end
        end
        PhDigits: begin
          digit_step = 1'b1;
        end
        default: begin
        end
      endcase
      if (prefix_step) begin
        if (radix_i == BASE_AUTO) begin
          if (tok_i.zero) begin
            consume = 1'b1;
            phase_d = PhZero;
          end else begin
            base_d     = BASE_DEC;
            mul_base   = BASE_DEC;
            digit_step = 1'b1;
          end
        end else begin
          base_d     = radix_i;
          mul_base   = radix_i;
          digit_step = 1'b1;
        end
      end
      if (digit_step) begin
        if (tok_i.digit < mul_base) begin
          acc_d   = product + delta;
          consume = 1'b1;
          phase_d = PhDigits;
        end else begin
          phase_d = PhDone;
        end
      end
    end
    cnt_d = (consume && cnt_q < CntLimit) ? cnt_q + 1'b1 : cnt_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (tok_pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWs;
      base_q      <= '0;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (tok_pop_o) begin
        if (emit) begin
          phase_q <= PhWs;
          base_q  <= '0;
          neg_q   <= 1'b0;
          acc_q   <= '0;
          cnt_q   <= '0;
        end else begin
          phase_q <= phase_d;
          base_q  <= base_d;
          neg_q   <= neg_d;
          acc_q   <= acc_d;
          cnt_q   <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o && emit) begin
      value_q  <= acc_d;
      offset_q <= cnt_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign end_offset_o = offset_q;

endmodule

### design/text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// Text-to-integer parser
// Streams characters of a string and returns its integer value in the
// configured or detected base, with the count of characters consumed.
//
// Channel   Direction  Handshake                  Payload
// in        request    in_valid_i / in_ready_o    ch_i, last_i
// out       result     out_valid_o / out_ready_i  value_o, end_offset_o
// radix     write      radix_we_i                 radix_wdata_i
//
// One character is accepted every cycle while the queue has room; the back
// end's single 64 by 5 bit multiply-add per character sets this rate.
// Reset clears the parsing state and sets the radix to ten. A stalled
// result stops only the back end; the two-entry queue keeps accepting
// characters until it fills.
// ----------------------------------------------------------------------------
module text_to_integer_parser #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                radix_we_i,
  input  logic [ttip_pkg::RADIX_W-1:0]        radix_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ttip_pkg::CH_W-1:0]           ch_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ttip_pkg::VALUE_W-1:0] value_o,
  output logic [ttip_pkg::CNT_W-1:0]          end_offset_o
);
  import ttip_pkg::*;

  localparam int unsigned CntLimit = (MAX_LEN < CNT_FIELD_MAX) ? MAX_LEN : CNT_FIELD_MAX;

  logic [RADIX_W-1:0] radix_q;
  tok_t               tok_in, tok_head;
  logic               tok_valid, tok_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= BASE_DEC;
    end else if (radix_we_i) begin
      radix_q <= radix_wdata_i;
    end
  end

  ttip_front u_front (
    .ch_i   (ch_i),
    .last_i (last_i),
    .tok_o  (tok_in)
  );

  ttip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (tok_in),
    .ready_o (in_ready_o),
    .valid_o (tok_valid),
    .pop_i   (tok_pop),
    .data_o  (tok_head)
  );

  ttip_back #(
    .CntLimit (CNT_W'(CntLimit))
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_i      (radix_q),
    .tok_valid_i  (tok_valid),
    .tok_i        (tok_head),
    .tok_pop_o    (tok_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .end_offset_o (end_offset_o)
  );

endmodule
